FILE: design/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition c in the same cycle
`define ASSERT_IMPLIES(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// condition a implies condition c in the following cycle
`define ASSERT_NEXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

FILE: design/ellspmv_pkg.sv
// shared types and constants for the ellpack sparse matrix-vector core
// no dependencies
`timescale 1ns / 1ps

package ellspmv_pkg;

    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;
    localparam int COLE_W = 13;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // column entry: top bit marks an empty slot
    localparam logic [COLE_W-1:0] COL_EMPTY = 13'h1000;

    typedef enum logic [1:0] {
        KIND_VEC_WR   = 2'd0,
        KIND_SET_COEF = 2'd1,
        KIND_CLR_ROW  = 2'd2,
        KIND_MUL_ROW  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FULL,
        RES_SUM
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_CLR,
        ST_MUL_RD,
        ST_MUL_VEC,
        ST_MUL_PROD,
        ST_MUL_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_item;
        logic     sweep_en;
        logic     col_rd;
        logic     col_wr;
        logic     col_empty;
        logic     coef_wr;
        logic     vec_wr;
        logic     vec_rd;
        logic     mul_en;
        logic     acc_clr;
        logic     acc_en;
        logic     out_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  row_ok;
        logic  col_ok;
        logic  slot_empty;
        logic  slot_match;
        logic  out_free;
    } dp_stat_t;

endpackage

FILE: design/ellspmv_req_if.sv
// request channel: valid/ready handshake with item payload
// depends on ellspmv_pkg
`timescale 1ns / 1ps

interface ellspmv_req_if import ellspmv_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    idx_t       row;
    idx_t       column;
    data_t      value;

    modport source (output valid, kind, row, column, value, input ready);
    modport sink (input valid, kind, row, column, value, output ready);
endinterface

FILE: design/ellspmv_rsp_if.sv
// response channel: valid/ready handshake with result payload
// depends on ellspmv_pkg
`timescale 1ns / 1ps

interface ellspmv_rsp_if import ellspmv_pkg::*; ();
    logic       valid;
    logic       ready;
    data_t      product;
    logic [1:0] status;

    modport source (output valid, product, status, input ready);
    modport sink (input valid, product, status, output ready);
endinterface

FILE: design/ellspmv_dp.sv
// datapath: item registers, slot/coefficient/vector memories, multiplier,
// accumulator, saturation and output register; depends on ellspmv_pkg
`timescale 1ns / 1ps

module ellspmv_dp import ellspmv_pkg::*; #(
    parameter int ROWS  = 4096,
    parameter int SLOTS = 8,
    localparam int RW   = $clog2(ROWS),
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int AW   = RW + SW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       cmd,
    input  logic [SW-1:0] slot,
    input  logic [AW-1:0] sweep,
    input  logic [1:0]    kind,
    input  idx_t          row,
    input  idx_t          column,
    input  data_t         value,
    input  logic          rsp_ready,
    output dp_stat_t      stat,
    output logic          out_valid,
    output data_t         product,
    output logic [1:0]    status
);

    localparam int DEPTH = ROWS << SW;
    localparam int XW    = 17;
    localparam int RND_W = 48;
    localparam int ACC_W = RND_W + SW;
    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sd2147483648);

    logic [COLE_W-1:0] col_mem  [DEPTH];
    logic [DATA_W-1:0] coef_mem [DEPTH];
    logic [DATA_W-1:0] vec_mem  [ROWS];

    kind_t              kind_reg;
    idx_t               row_reg;
    idx_t               column_reg;
    data_t              value_reg;
    logic [COLE_W-1:0]  col_rd_reg;
    data_t              coef_rd_reg;
    data_t              vec_rd_reg;
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               out_valid_reg;
    data_t              product_reg;
    logic [1:0]         status_reg;

    logic [XW-1:0]      row_x;
    logic [XW-1:0]      col_x;
    logic [XW-1:0]      vcol_x;
    logic [AW-1:0]      addr;
    logic [COLE_W-1:0]  col_wdata;
    logic signed [63:0] rnd_sum;
    logic [RND_W-1:0]   rnd;
    data_t              res_product;
    logic [1:0]         res_status;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg   <= kind_t'(kind);
            row_reg    <= row;
            column_reg <= column;
            value_reg  <= value;
        end
    end

    assign row_x  = XW'(row_reg);
    assign col_x  = XW'(column_reg);
    assign vcol_x = XW'(col_rd_reg[IDX_W-1:0]);

    assign addr      = cmd.sweep_en ? sweep : {row_x[RW-1:0], slot};
    assign col_wdata = cmd.col_empty ? COL_EMPTY : {1'b0, column_reg};

    // slot memories share one address; column and coefficient read together
    always_ff @(posedge clk)
    begin
        if (cmd.col_wr)
        begin
            col_mem[addr] <= col_wdata;
        end
        if (cmd.col_rd)
        begin
            col_rd_reg <= col_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr)
        begin
            coef_mem[addr] <= value_reg;
        end
        if (cmd.col_rd)
        begin
            coef_rd_reg <= coef_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vec_wr)
        begin
            vec_mem[row_x[RW-1:0]] <= value_reg;
        end
        if (cmd.vec_rd)
        begin
            vec_rd_reg <= vec_mem[vcol_x[RW-1:0]];
        end
    end

    // signed 32 by 32 product, both operands sign extended
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= 64'(coef_rd_reg) * 64'(vec_rd_reg);
        end
    end

    // round half up to q16.16, then accumulate exactly
    assign rnd_sum = prod_reg + 64'sd32768;
    assign rnd     = rnd_sum[63:16];

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'($signed(rnd));
        end
    end

    always_comb
    begin
        res_product = '0;
        res_status  = STATUS_OK;
        unique case (cmd.res_sel)
            RES_ZERO:
            begin
                res_product = '0;
                res_status  = STATUS_OK;
            end
            RES_FULL:
            begin
                res_product = '0;
                res_status  = STATUS_FULL;
            end
            RES_SUM:
            begin
                if (acc_reg > SUM_MAX)
                begin
                    res_product = 32'sh7fff_ffff;
                    res_status  = STATUS_SAT;
                end
                else if (acc_reg < SUM_MIN)
                begin
                    res_product = 32'sh8000_0000;
                    res_status  = STATUS_SAT;
                end
                else
                begin
                    res_product = acc_reg[DATA_W-1:0];
                    res_status  = STATUS_OK;
                end
            end
            default:
            begin
                res_product = '0;
                res_status  = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            product_reg <= res_product;
            status_reg  <= res_status;
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.row_ok     = row_x < XW'(ROWS);
    assign stat.col_ok     = col_x < XW'(ROWS);
    assign stat.slot_empty = col_rd_reg[COLE_W-1];
    assign stat.slot_match = !col_rd_reg[COLE_W-1] && (col_rd_reg[IDX_W-1:0] == column_reg);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign status    = status_reg;

endmodule

FILE: design/ellspmv_ctrl.sv
// controller: state machine, slot counter and post-reset clearing sweep
// depends on ellspmv_pkg
`timescale 1ns / 1ps

module ellspmv_ctrl import ellspmv_pkg::*; #(
    parameter int ROWS  = 4096,
    parameter int SLOTS = 8,
    localparam int RW   = $clog2(ROWS),
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int AW   = RW + SW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dp_stat_t      stat,
    output dp_cmd_t       cmd,
    output logic [SW-1:0] slot,
    output logic [AW-1:0] sweep
);

    localparam int DEPTH = ROWS << SW;

    state_t        state_reg,   state_next;
    logic [SW-1:0] slot_reg,    slot_next;
    logic [AW-1:0] sweep_reg,   sweep_next;
    res_sel_t      res_sel_reg, res_sel_next;

    logic slot_last;
    logic sweep_last;

    assign slot_last  = slot_reg == SW'(SLOTS - 1);
    assign sweep_last = sweep_reg == AW'(DEPTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            slot_reg    <= '0;
            sweep_reg   <= '0;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            sweep_reg   <= sweep_next;
            res_sel_reg <= res_sel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        sweep_next   = sweep_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        req_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_en  = 1'b1;
                cmd.col_wr    = 1'b1;
                cmd.col_empty = 1'b1;
                sweep_next    = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    slot_next     = '0;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                res_sel_next = RES_ZERO;
                if (!stat.row_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    unique case (stat.kind)
                        KIND_VEC_WR:
                        begin
                            cmd.vec_wr = 1'b1;
                            state_next = ST_DONE;
                        end
                        KIND_SET_COEF:
                        begin
                            state_next = stat.col_ok ? ST_SRCH_RD : ST_DONE;
                        end
                        KIND_CLR_ROW:
                        begin
                            state_next = ST_CLR;
                        end
                        KIND_MUL_ROW:
                        begin
                            cmd.acc_clr = 1'b1;
                            state_next  = ST_MUL_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                cmd.col_rd = 1'b1;
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK:
            begin
                // first slot holding the column or empty takes the value
                if (stat.slot_match || stat.slot_empty)
                begin
                    cmd.col_wr  = 1'b1;
                    cmd.coef_wr = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (slot_last)
                begin
                    res_sel_next = RES_FULL;
                    state_next   = ST_DONE;
                end
                else
                begin
                    slot_next  = slot_reg + SW'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_CLR:
            begin
                cmd.col_wr    = 1'b1;
                cmd.col_empty = 1'b1;
                if (slot_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                end
            end
            ST_MUL_RD:
            begin
                cmd.col_rd = 1'b1;
                state_next = ST_MUL_VEC;
            end
            ST_MUL_VEC:
            begin
                if (stat.slot_empty)
                begin
                    res_sel_next = RES_SUM;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.vec_rd = 1'b1;
                    state_next = ST_MUL_PROD;
                end
            end
            ST_MUL_PROD:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_ACC;
            end
            ST_MUL_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (slot_last)
                begin
                    res_sel_next = RES_SUM;
                    state_next   = ST_DONE;
                end
                else
                begin
                    slot_next  = slot_reg + SW'(1);
                    state_next = ST_MUL_RD;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot  = slot_reg;
    assign sweep = sweep_reg;

endmodule

FILE: design/ell_sparse_matrix_vector_multiply_core.sv
// ellpack sparse matrix-vector core, one request at a time
// a set searches the slots in order, a row clear empties every slot of the row, and a
// multiply reads slot by slot and stops at the first empty slot; the next request is
// taken the cycle after the response is loaded, even if unread; reset: async active
// low, then a sweep over all ROWS << SW entries empties every slot
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ell_sparse_matrix_vector_multiply_core import ellspmv_pkg::*; #(
    parameter int ROWS  = 4096,
    parameter int SLOTS = 8
) (
    input logic          clk,
    input logic          rst_n,
    ellspmv_req_if.sink  req,
    ellspmv_rsp_if.source rsp
);

    localparam int RW = $clog2(ROWS);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = RW + SW;

    // command and status between controller and datapath
    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [SW-1:0] slot;
    logic [AW-1:0] sweep;

    // response currently offered carries the row full status
    logic          full_rsp;

    // controller owns the sequencing: dispatch, slot walk, clearing sweep
    ellspmv_ctrl #(
        .ROWS  (ROWS),
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd),
        .slot      (slot),
        .sweep     (sweep)
    );

    // datapath holds the memories, the multiply-accumulate and the output register
    ellspmv_dp #(
        .ROWS  (ROWS),
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .slot      (slot),
        .sweep     (sweep),
        .kind      (req.kind),
        .row       (req.row),
        .column    (req.column),
        .value     (req.value),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .out_valid (rsp.valid),
        .product   (rsp.product),
        .status    (rsp.status)
    );

    assign full_rsp = rsp.valid && (rsp.status == STATUS_FULL);

    // a response is loaded only into a free output register
    `ASSERT_IMPLIES(a_load_free, cmd.out_load, stat.out_free, "response loaded over unread result")
    // only one request in flight
    `ASSERT_NEXT(a_one_inflight, req.valid && req.ready, !req.ready, "request taken while busy")
    // no request is taken while the slot store is being swept
    `ASSERT_IMPLIES(a_sweep_busy, cmd.sweep_en, !req.ready, "request taken during clearing sweep")
    // a full row reports a zero product
    `ASSERT_IMPLIES(a_full_zero, full_rsp, rsp.product == '0, "row full with nonzero product")

endmodule
